>>> hdl/bassr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bassr_pkg
// Shared types and constants for the bit-aligned sync search and realigner.
// ---------------------------------------------------------------------------
package bassr_pkg;

	// Default sync pattern (block magic) and default offset counter width
	localparam logic [47:0] SYNC_PATTERN_DEFAULT = 48'h314159265359;
	localparam int          OFFSET_BITS_DEFAULT  = 32;

	// Result kinds
	localparam logic [1:0] KIND_SYNC_FOUND = 2'd0;
	localparam logic [1:0] KIND_DATA       = 2'd1;
	localparam logic [1:0] KIND_NOT_FOUND  = 2'd2;

	// Result queue depth: one held result plus room for two more
	localparam int QUEUE_DEPTH = 3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_val;
		logic [31:0] offset;
		logic [2:0]  shift;
		logic        final_flag;
	} result_t;

endpackage

`default_nettype wire

>>> hdl/bit_aligned_sync_search_realign.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bit_aligned_sync_search_realign
// Bit-aligned 48-bit sync search over a byte stream, with realigned output.
// ---------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_ready is high. Each accepted byte
// is shifted into a seven-byte window that is compared against the sync pattern at
// all eight bit offsets in parallel, in the same cycle as the state update; the lowest
// shift that fits wins. The zero to two results a byte causes are written into a
// three-entry registered result queue and presented on the output from its head.
// in_ready depends only on the queue fill: it is high while the queue holds at most
// one result, so with the output side always ready a new byte is taken every cycle,
// and after a byte that causes two results (the last byte with a non-zero shift) the
// input pauses until the queue drains to one result. Configuration writes are taken
// at once (cfg_ready is always high) and should be made only while the block is idle.
// ---------------------------------------------------------------------------
module bit_aligned_sync_search_realign
	import bassr_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [47:0] cfg_data,
	// Input byte channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        is_last,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       result_kind,
	output logic [7:0]       aligned_byte,
	output logic [31:0]      sync_offset,
	output logic [2:0]       sync_shift,
	output logic             final_item
);

	localparam int OFF_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

	// Registers
	logic [47:0]            pattern_q;
	logic [55:0]            window_q;
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   found_q;
	logic [2:0]             shift_q;
	result_t                queue_q [QUEUE_DEPTH];
	logic [1:0]             fill_q;

	// Next-state and result logic
	logic [55:0]            window_n;
	logic [OFFSET_BITS-1:0] seen_n;
	logic [7:0]             match_vec;
	logic                   match_any;
	logic [2:0]             match_shift;
	logic [OFFSET_BITS-1:0] match_off;
	logic [OFF_W-1:0]       match_off_w;
	logic [31:0]            match_off_sat;
	logic [7:0]             realigned;
	logic [7:0]             padded;
	result_t                res0;
	result_t                res1;
	logic [1:0]             res_count;
	logic                   push;
	logic                   pop;
	logic [1:0]             base;
	result_t                queue_n [QUEUE_DEPTH];

	assign cfg_ready = 1'b1;
	assign in_ready  = (fill_q <= 2'd1);
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	// Shift in the new byte and advance the saturating byte count
	assign window_n = {window_q[47:0], data_byte};
	assign seen_n   = (seen_q == '1) ? seen_q : seen_q + 1'b1;

	// Compare the pattern at all eight bit offsets
	always_comb begin
		match_vec[0] = (window_n[47:0] == pattern_q);
		for (int i = 1; i < 8; i++) begin
			match_vec[i] = (window_n[55-i -: 48] == pattern_q);
		end
	end

	// Pick the lowest fitting shift
	always_comb begin
		match_shift = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (match_vec[i]) begin
				match_shift = 3'(i);
			end
		end
	end

	assign match_any = (|match_vec) & (seen_n >= OFFSET_BITS'(7));

	// Offset of the byte holding the first pattern bit, saturated to 32 bits
	assign match_off   = seen_n - ((match_shift == 3'd0) ? OFFSET_BITS'(6) : OFFSET_BITS'(7));
	assign match_off_w = OFF_W'(match_off);
	assign match_off_sat = (match_off_w > OFF_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
	                                                              : match_off_w[31:0];

	// Realigned byte from the window and the padded final byte
	assign realigned = (shift_q == 3'd0) ? data_byte : window_n[6'd15 - 6'(shift_q) -: 8];
	assign padded    = (found_q) ? 8'(data_byte << shift_q) : 8'(data_byte << match_shift);

	// Build the results of this request
	always_comb begin
		res0      = '0;
		res1      = '0;
		res_count = 2'd0;
		if (found_q) begin
			res0.kind       = KIND_DATA;
			res0.byte_val   = realigned;
			res0.final_flag = is_last & (shift_q == 3'd0);
			res_count       = 2'd1;
			if (is_last && shift_q != 3'd0) begin
				res1.kind       = KIND_DATA;
				res1.byte_val   = padded;
				res1.final_flag = 1'b1;
				res_count       = 2'd2;
			end
		end else if (match_any) begin
			res0.kind       = KIND_SYNC_FOUND;
			res0.offset     = match_off_sat;
			res0.shift      = match_shift;
			res0.final_flag = is_last & (match_shift == 3'd0);
			res_count       = 2'd1;
			if (is_last && match_shift != 3'd0) begin
				res1.kind       = KIND_DATA;
				res1.byte_val   = padded;
				res1.final_flag = 1'b1;
				res_count       = 2'd2;
			end
		end else if (is_last) begin
			res0.kind       = KIND_NOT_FOUND;
			res0.final_flag = 1'b1;
			res_count       = 2'd1;
		end
	end

	// Advance the queue on a pop and append new results behind the survivors
	always_comb begin
		base = fill_q - {1'b0, pop};
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (pop && i < QUEUE_DEPTH - 1) begin
				queue_n[i] = queue_q[i+1];
			end else begin
				queue_n[i] = queue_q[i];
			end
		end
		if (push && res_count != 2'd0) begin
			queue_n[base] = res0;
		end
		if (push && res_count == 2'd2) begin
			queue_n[2'(base + 2'd1)] = res1;
		end
	end

	// Hold the sync pattern register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= SYNC_PATTERN_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			pattern_q <= cfg_data;
		end
	end

	// Update the stream state; drop it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			found_q  <= 1'b0;
			shift_q  <= 3'd0;
		end else if (push) begin
			if (is_last) begin
				window_q <= '0;
				seen_q   <= '0;
				found_q  <= 1'b0;
				shift_q  <= 3'd0;
			end else begin
				window_q <= window_n;
				seen_q   <= seen_n;
				if (!found_q && match_any) begin
					found_q <= 1'b1;
					shift_q <= match_shift;
				end
			end
		end
	end

	// Queue fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			fill_q <= fill_q - {1'b0, pop} + (push ? res_count : 2'd0);
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_q[i] <= queue_n[i];
		end
	end

	// Present the queue head
	assign out_valid    = (fill_q != 2'd0);
	assign result_kind  = queue_q[0].kind;
	assign aligned_byte = queue_q[0].byte_val;
	assign sync_offset  = queue_q[0].offset;
	assign sync_shift   = queue_q[0].shift;
	assign final_item   = queue_q[0].final_flag;

	// Assertions
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'd3)
		else $error("result queue overfilled");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && is_last) |=> (!found_q && seen_q == '0))
		else $error("stream state not cleared after last byte");

	a_report_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !found_q && match_any && !is_last) |=> (found_q && shift_q == $past(match_shift)))
		else $error("sync report did not lock the shift");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push && res_count != 2'd0) |=> out_valid)
		else $error("pushed result not presented");

endmodule

`default_nettype wire

>>> bench/tb_bit_aligned_sync_search_realign.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bit_aligned_sync_search_realign
// Self-checking bench for the bit-aligned sync search and realigner.
// ---------------------------------------------------------------------------
// A short table of hand-made streams runs first with the reset pattern: a lone
// last byte, a pattern that arrives too early, shift 0 matched on the last byte,
// and shift 7 followed by realigned data and the padded tail byte. Random
// phases follow, each with its own sync pattern (all zeros, all ones, the
// default, only the top and bottom bits set, random). Most streams carry the
// pattern at a random bit offset among random bytes. Others are pure noise,
// carry a pattern with one bit flipped, or stop within the seven bytes that
// hold the pattern. Every accepted byte runs through a local model of the
// search and realign logic, and each result from the block is checked field
// by field against the oldest expected result. Both sides stall at random.
// ---------------------------------------------------------------------------
module tb_bit_aligned_sync_search_realign
	import bassr_pkg::*;
();

	localparam logic [55:0] FIELD_MASK    = 56'h00FFFFFFFFFFFF;
	localparam int          STALL_LIMIT   = 1000;
	localparam int          PHASE_BYTES   = 250;
	localparam int          SETTLE_CYCLES = 4;

	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         typed;
		result_t    want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  aligned_byte;
	logic [31:0] sync_offset;
	logic [2:0]  sync_shift;
	logic        final_item;

	// Expectation typed in by the table row now on the input, if any
	bit      cur_typed = 1'b0;
	result_t cur_want = '0;

	// Local copy of the block's state
	logic [47:0] model_pattern = SYNC_PATTERN_DEFAULT;
	logic [55:0] win_bytes = '0;
	logic [31:0] byte_count = '0;
	bit          locked = 1'b0;
	logic [2:0]  lock_shift = '0;
	result_t     step_out [2];

	result_t     pending_results [$];
	logic [7:0]  stream_bytes [$];
	stim_row_t   dir_rows [];
	int          mismatch_count = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	bit          idle_on = 1'b1;

	bit_aligned_sync_search_realign DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.aligned_byte (aligned_byte),
		.sync_offset  (sync_offset),
		.sync_shift   (sync_shift),
		.final_item   (final_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Shift one byte through the search window; fill step_out, return the count
	function automatic int search_and_realign(logic [7:0] b, logic is_end);
		int          n;
		int          s;
		bit          hit;
		logic [2:0]  hit_shift;
		logic [47:0] field;
		logic [7:0]  a;
		n = 0;
		hit = 1'b0;
		hit_shift = '0;
		win_bytes = {win_bytes[47:0], b};
		if (byte_count != '1)
			byte_count = byte_count + 1;
		if (locked) begin
			a = (lock_shift == 0) ? b : 8'(win_bytes >> (8 - lock_shift));
			step_out[n++] = '{KIND_DATA, a, 32'd0, 3'd0, is_end && lock_shift == 0};
			if (is_end && lock_shift != 0)
				step_out[n++] = '{KIND_DATA, 8'(b << lock_shift), 32'd0, 3'd0, 1'b1};
		end else begin
			if (byte_count >= 7) begin
				for (s = 0; s < 8; s++) begin
					field = (s == 0) ? win_bytes[47:0] : 48'(win_bytes >> (8 - s));
					if (!hit && field == model_pattern) begin
						hit = 1'b1;
						hit_shift = 3'(s);
					end
				end
				if (hit) begin
					locked = 1'b1;
					lock_shift = hit_shift;
					step_out[n++] = '{KIND_SYNC_FOUND, 8'd0,
						byte_count - ((hit_shift == 0) ? 32'd6 : 32'd7), hit_shift,
						is_end && hit_shift == 0};
					if (is_end && hit_shift != 0)
						step_out[n++] = '{KIND_DATA, 8'(b << hit_shift), 32'd0, 3'd0, 1'b1};
				end
			end
			if (!locked && is_end)
				step_out[n++] = '{KIND_NOT_FOUND, 8'd0, 32'd0, 3'd0, 1'b1};
		end
		// Drop the stream state after its last byte
		if (is_end) begin
			win_bytes = '0;
			byte_count = '0;
			locked = 1'b0;
			lock_shift = '0;
		end
		return n;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Predict on accepted requests, check accepted results
	always @(posedge clk) begin
		int      n;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_pattern = cfg_data;
			if (in_valid && in_ready) begin
				n = search_and_realign(data_byte, is_last);
				if (cur_typed)
					pending_results.push_back(cur_want);
				else
					for (int i = 0; i < n; i++)
						pending_results.push_back(step_out[i]);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with none expected");
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", result_kind, want.kind);
					check_field("aligned_byte", aligned_byte, want.byte_val);
					check_field("sync_offset", sync_offset, want.offset);
					check_field("sync_shift", sync_shift, want.shift);
					check_field("final_item", final_item, want.final_flag);
				end
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 5) == 0)
				stall_left <= pick_gap();
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("bit_aligned_sync_search_realign regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one byte, hold it until the request is taken
	task automatic send_byte(input logic [7:0] b, input logic is_end, input bit typed,
		input result_t want);
		int g;
		g = idle_on ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_last <= is_end;
		cur_typed <= typed;
		cur_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Idle the input and let every expected result drain
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pattern(input logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Build one stream: mostly a pattern at a random bit offset inside random bytes
	function automatic void build_stream(logic [47:0] pat);
		logic [55:0] chunk;
		int          style;
		int          s;
		int          len;
		stream_bytes.delete();
		style = $urandom_range(0, 9);
		s = $urandom_range(0, 7);
		chunk = 56'({$urandom(), $urandom()});
		chunk = (chunk & ~(FIELD_MASK << (8 - s))) | ({8'd0, pat} << (8 - s));
		if (style <= 7) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
			repeat (len) stream_bytes.push_back(8'($urandom()));
			// Break the pattern by one bit
			if (style == 7)
				chunk = chunk ^ (56'd1 << (8 - s + $urandom_range(0, 47)));
			for (int i = 0; i < 7; i++)
				stream_bytes.push_back(chunk[55 - 8 * i -: 8]);
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 5);
			repeat (len) stream_bytes.push_back(8'($urandom()));
		end else if (style == 8) begin
			len = $urandom_range(1, 24);
			repeat (len) stream_bytes.push_back(8'($urandom()));
		end else begin
			// Send only the first one to seven of the pattern bytes
			len = $urandom_range(1, 7);
			for (int i = 0; i < len; i++)
				stream_bytes.push_back(chunk[55 - 8 * i -: 8]);
		end
	endfunction

	initial begin
		logic [47:0] phase_pattern;
		int          sent;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-made streams against the reset pattern
		dir_rows = '{
			// lone last byte
			'{8'hFF, 1'b1, 1'b1, '{KIND_NOT_FOUND, 8'h00, 32'd0, 3'd0, 1'b1}},
			// pattern in the first six bytes: too early to match
			'{8'h31, 1'b0, 1'b0, '0},
			'{8'h41, 1'b0, 1'b0, '0},
			'{8'h59, 1'b0, 1'b0, '0},
			'{8'h26, 1'b0, 1'b0, '0},
			'{8'h53, 1'b0, 1'b0, '0},
			'{8'h59, 1'b0, 1'b0, '0},
			'{8'h00, 1'b1, 1'b1, '{KIND_NOT_FOUND, 8'h00, 32'd0, 3'd0, 1'b1}},
			// shift 0 found on the last byte
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h31, 1'b0, 1'b0, '0},
			'{8'h41, 1'b0, 1'b0, '0},
			'{8'h59, 1'b0, 1'b0, '0},
			'{8'h26, 1'b0, 1'b0, '0},
			'{8'h53, 1'b0, 1'b0, '0},
			'{8'h59, 1'b1, 1'b1, '{KIND_SYNC_FOUND, 8'h00, 32'd1, 3'd0, 1'b1}},
			// shift 7, then one realigned byte and the padded tail
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h62, 1'b0, 1'b0, '0},
			'{8'h82, 1'b0, 1'b0, '0},
			'{8'hB2, 1'b0, 1'b0, '0},
			'{8'h4C, 1'b0, 1'b0, '0},
			'{8'hA6, 1'b0, 1'b0, '0},
			'{8'hB2, 1'b0, 1'b0, '0},
			'{8'h5A, 1'b1, 1'b0, '0}
		};
		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].want);
		wait_drained();

		// Random phases, one sync pattern each
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: phase_pattern = 48'h000000000000;
				1: phase_pattern = 48'hFFFFFFFFFFFF;
				2: phase_pattern = SYNC_PATTERN_DEFAULT;
				3: phase_pattern = 48'h800000000001;
				default: phase_pattern = 48'({$urandom(), $urandom()});
			endcase
			write_pattern(phase_pattern);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_stream(phase_pattern);
				foreach (stream_bytes[i])
					send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, '0);
				sent += stream_bytes.size();
				idle_on <= ($urandom_range(0, 3) != 0);
			end
			wait_drained();
		end

		// Hold off a while for stray results, then close
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never came",
				pending_results.size()));
		if (mismatch_count == 0)
			$display("bit_aligned_sync_search_realign regression: pass");
		else
			$display("bit_aligned_sync_search_realign regression: fail");
		$finish;
	end

endmodule
